// ===== rtl/multichannel_led_pattern_generator_defines.svh =====
// ----------------------------------------------------------------------------
// LED pattern generator assertion macros
// Shared concurrent assertion shorthands for the LED pattern generator RTL.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_LED_PATTERN_GENERATOR_DEFINES_SVH
`define MULTICHANNEL_LED_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LPG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define LPG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pattern generator package
// Beat types, command codes, per-channel entry layout and control states.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   // Request mode codes
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_OFF   = 3'd1;
   localparam logic [2:0] REQ_ON    = 3'd2;
   localparam logic [2:0] REQ_BLINK = 3'd3;
   localparam logic [2:0] REQ_PULSE = 3'd4;
   localparam logic [2:0] REQ_TRAIN = 3'd5;

   // CSR map
   localparam logic [2:0] CSR_ADDR_CIN = 3'd0;
   localparam logic [3:0] CIN_RESET    = 4'd8;

   typedef enum logic [2:0] {
      CM_OFF   = 3'd0,
      CM_ON    = 3'd1,
      CM_BLINK = 3'd2,
      CM_PULSE = 3'd3,
      CM_TRAIN = 3'd4
   } lpg_chan_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_TICK
   } lpg_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  channel;
      logic [15:0] period;
      logic [7:0]  high_count;
      logic [7:0]  low_count;
   } lpg_req_type;

   typedef struct packed {
      logic [7:0] led_levels;
      logic       accepted;
   } lpg_rsp_type;

   // One channel's stored pattern state; all zero means off.
   typedef struct packed {
      lpg_chan_mode_type mode;
      logic [15:0]       period;
      logic [8:0]        high;
      logic [7:0]        low;
      logic [15:0]       phase;
      logic [15:0]       prescale;
   } lpg_entry_type;

endpackage

`default_nettype wire

// ===== rtl/lpg_chan_mem.sv =====
// ----------------------------------------------------------------------------
// LED pattern generator channel memory
// One-read one-write channel state store, registered read, per-entry valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_chan_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output lpg_pkg::lpg_entry_type     rd_data,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire lpg_pkg::lpg_entry_type wr_data
);

   lpg_pkg::lpg_entry_type chan_mem_ff [DEPTH];
   lpg_pkg::lpg_entry_type rdata_ff;
   logic                   rvld_ff;
   logic [DEPTH-1:0]       valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chan_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= chan_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvld_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entry reads as reset state (off, all zero)
   assign rd_data = rvld_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/lpg_update.sv =====
// ----------------------------------------------------------------------------
// LED pattern generator entry update
// Next channel state and LED level for a command or for one tick step.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_update (
   input  wire lpg_pkg::lpg_req_type   cmd,
   input  wire lpg_pkg::lpg_entry_type ent_cur,
   input  wire logic                   led_cur,
   output lpg_pkg::lpg_entry_type      ent_nxt,
   output logic                        led_nxt
);

   logic [16:0] presc_sum;
   logic [16:0] phase_sum;
   logic [9:0]  span;

   always_comb begin
      ent_nxt   = ent_cur;
      led_nxt   = led_cur;
      presc_sum = {1'b0, ent_cur.prescale} + 17'd1;
      phase_sum = {1'b0, ent_cur.phase} + 17'd1;
      span      = {1'b0, ent_cur.high} + {2'b00, ent_cur.low};
      case (cmd.mode)
         lpg_pkg::REQ_TICK: begin
            if (ent_cur.mode inside {lpg_pkg::CM_BLINK, lpg_pkg::CM_PULSE,
                                     lpg_pkg::CM_TRAIN}) begin
               if (presc_sum >= {1'b0, ent_cur.period}) begin
                  ent_nxt.prescale = '0;
                  case (ent_cur.mode)
                     lpg_pkg::CM_BLINK: begin
                        ent_nxt.phase = phase_sum[15:0];
                        if (phase_sum == 17'(ent_cur.low)) begin
                           led_nxt = 1'b1;
                        end else if (phase_sum == 17'(span)) begin
                           led_nxt       = 1'b0;
                           ent_nxt.phase = '0;
                        end
                     end
                     lpg_pkg::CM_PULSE: begin
                        led_nxt      = 1'b0;
                        ent_nxt.mode = lpg_pkg::CM_OFF;
                     end
                     lpg_pkg::CM_TRAIN: begin
                        ent_nxt.phase = phase_sum[15:0];
                        if (phase_sum <= 17'(ent_cur.high)) begin
                           led_nxt = phase_sum[0];
                        end else if (phase_sum == 17'(span)) begin
                           led_nxt       = 1'b0;
                           ent_nxt.phase = '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  ent_nxt.prescale = presc_sum[15:0];
               end
            end
         end
         lpg_pkg::REQ_OFF: begin
            if (ent_cur.mode != lpg_pkg::CM_OFF) begin
               ent_nxt.mode = lpg_pkg::CM_OFF;
               led_nxt      = 1'b0;
            end
         end
         lpg_pkg::REQ_ON: begin
            if (ent_cur.mode != lpg_pkg::CM_ON) begin
               ent_nxt.mode = lpg_pkg::CM_ON;
               led_nxt      = 1'b1;
            end
         end
         lpg_pkg::REQ_BLINK: begin
            ent_nxt.mode     = lpg_pkg::CM_BLINK;
            ent_nxt.period   = cmd.period;
            ent_nxt.high     = {1'b0, cmd.high_count};
            ent_nxt.low      = cmd.low_count;
            ent_nxt.phase    = '0;
            ent_nxt.prescale = '0;
         end
         lpg_pkg::REQ_TRAIN: begin
            // two phases per pulse
            ent_nxt.mode     = lpg_pkg::CM_TRAIN;
            ent_nxt.period   = cmd.period;
            ent_nxt.high     = {cmd.high_count, 1'b0};
            ent_nxt.low      = cmd.low_count;
            ent_nxt.phase    = '0;
            ent_nxt.prescale = '0;
         end
         lpg_pkg::REQ_PULSE: begin
            ent_nxt.mode     = lpg_pkg::CM_PULSE;
            ent_nxt.period   = cmd.period;
            ent_nxt.phase    = '0;
            ent_nxt.prescale = '0;
            led_nxt          = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/multichannel_led_pattern_generator.sv =====
// Response: registered in ST_CMD for a command beat, and with the last entry's
//   write-back in ST_TICK for a tick beat.
// Throughput: one beat at a time; a new beat is taken only back in ST_IDLE,
//   and a tick walks the memory one entry per cycle.
// Reset: synchronous, active high; all channels come up off with LEDs dark
//   at once through per-entry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
// Multichannel LED pattern generator
// Per-channel off/on/blink/pulse/train engine driven by commands and ticks,
// with channel state held in a synchronous memory and an APB-style CSR.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_led_pattern_generator_defines.svh"

module multichannel_led_pattern_generator #(
   parameter int NUM_CHANNELS = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire lpg_pkg::lpg_req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output lpg_pkg::lpg_rsp_type rsp_data,
   // CSR port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // entry index, walk counter (must hold NUM_CHANNELS), LED vector widths
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam int LED_W = (NUM_CHANNELS > 8) ? NUM_CHANNELS : 8;

   lpg_pkg::lpg_state_type state_ff, state_in;
   lpg_pkg::lpg_req_type   cmd_ff, cmd_in;
   logic                   acc_ff, acc_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [LED_W-1:0]       led_ff, led_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   lpg_pkg::lpg_rsp_type   rsp_ff, rsp_in;
   logic [3:0]             cin_ff, cin_in;

   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   lpg_pkg::lpg_entry_type mem_rd_data;
   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   lpg_pkg::lpg_entry_type upd_entry;
   logic                   upd_led;

   logic                   csr_wr_cin;
   logic                   chan_ok;
   logic                   args_ok;
   logic                   req_acc;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   // word decode: low byte-address bits are ignored
   assign csr_wr_cin = csr_psel && csr_penable && csr_pwrite &&
                       ({csr_paddr[2], 2'b00} == lpg_pkg::CSR_ADDR_CIN);
   assign cin_in     = csr_wr_cin ? csr_pwdata[3:0] : cin_ff;
   assign csr_prdata = ({csr_paddr[2], 2'b00} == lpg_pkg::CSR_ADDR_CIN) ?
                       {28'd0, cin_ff} : 32'd0;

   // -------------------------------------------------- command qualification
   // Channel must be below channels_in_use and exist in this build.
   assign chan_ok = ({1'b0, req_data.channel} < cin_ff) &&
                    (32'(req_data.channel) < NUM_CHANNELS);

   always_comb begin
      case (req_data.mode)
         lpg_pkg::REQ_OFF, lpg_pkg::REQ_ON: begin
            args_ok = 1'b1;
         end
         lpg_pkg::REQ_BLINK, lpg_pkg::REQ_TRAIN: begin
            args_ok = (req_data.period != 16'd0) && (req_data.high_count != 8'd0) &&
                      (req_data.low_count != 8'd0);
         end
         lpg_pkg::REQ_PULSE: begin
            args_ok = (req_data.period != 16'd0);
         end
         default: begin
            args_ok = 1'b0;   // unused modes are dropped
         end
      endcase
   end

   assign req_acc = (req_data.mode == lpg_pkg::REQ_TICK) || (chan_ok && args_ok);

   // ------------------------------------------------------- state memory
   lpg_chan_mem #(
      .DEPTH  (NUM_CHANNELS),
      .ADDR_W (IDX_W)
   ) u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (upd_entry)
   );

   // Update logic sees the entry read in the previous cycle. During a tick
   // walk cmd_ff holds the tick, so the same unit does both jobs.
   lpg_update u_update (
      .cmd     (cmd_ff),
      .ent_cur (mem_rd_data),
      .led_cur (led_ff[rd_idx_ff]),
      .ent_nxt (upd_entry),
      .led_nxt (upd_led)
   );

   // ------------------------------------------------------- control FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lpg_pkg::ST_IDLE;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         led_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         cin_ff     <= lpg_pkg::CIN_RESET;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_pend_in;
         led_ff     <= led_in;
         rsp_vld_ff <= rsp_vld_in;
         cin_ff     <= cin_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      acc_ff    <= acc_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = 1'b0;
      led_in      = led_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = rd_idx_ff;
      case (state_ff)
         lpg_pkg::ST_IDLE: begin
            // take a beat once the response slot is free or draining
            req_ready = !rsp_vld_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd_in    = req_data;
               acc_in    = req_acc;
               mem_rd_en = 1'b1;
               if (req_data.mode == lpg_pkg::REQ_TICK) begin
                  // start the walk at entry 0
                  mem_rd_addr = '0;
                  rd_idx_in   = '0;
                  rd_pend_in  = 1'b1;
                  cnt_in      = CNT_W'(1);
                  state_in    = lpg_pkg::ST_TICK;
               end else begin
                  // rejected commands read a harmless in-range entry
                  mem_rd_addr = chan_ok ? IDX_W'(req_data.channel) : '0;
                  rd_idx_in   = mem_rd_addr;
                  state_in    = lpg_pkg::ST_CMD;
               end
            end
         end
         lpg_pkg::ST_CMD: begin
            if (acc_ff) begin
               mem_wr_en         = 1'b1;
               led_in[rd_idx_ff] = upd_led;
            end
            rsp_vld_in         = 1'b1;
            rsp_in.led_levels  = led_in[7:0];
            rsp_in.accepted    = acc_ff;
            state_in           = lpg_pkg::ST_IDLE;
         end
         lpg_pkg::ST_TICK: begin
            // read next entry while the previous one is written back
            if (cnt_ff < CNT_W'(NUM_CHANNELS)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_ff[IDX_W-1:0];
               rd_idx_in   = cnt_ff[IDX_W-1:0];
               rd_pend_in  = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               mem_wr_en         = 1'b1;
               led_in[rd_idx_ff] = upd_led;
               if (rd_idx_ff == IDX_W'(NUM_CHANNELS - 1)) begin
                  rsp_vld_in        = 1'b1;
                  rsp_in.led_levels = led_in[7:0];
                  rsp_in.accepted   = 1'b1;
                  state_in          = lpg_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lpg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------- assertions
   `LPG_ASSERT_IMP(a_busy_rsp_empty, clock, reset,
      state_ff != lpg_pkg::ST_IDLE, !rsp_vld_ff,
      "response slot occupied while an item is in work")

   `LPG_ASSERT_IMP(a_no_rw_same_entry, clock, reset,
      mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr,
      "read and write-back hit the same channel entry")

   `LPG_ASSERT_IMP(a_write_in_work, clock, reset, mem_wr_en,
      (state_ff == lpg_pkg::ST_CMD) || (state_ff == lpg_pkg::ST_TICK && rd_pend_ff),
      "channel memory written outside command or tick write-back")

   `LPG_ASSERT_NXT(a_tick_done_accepted, clock, reset,
      state_ff == lpg_pkg::ST_TICK && state_in == lpg_pkg::ST_IDLE,
      rsp_vld_ff && rsp_ff.accepted,
      "tick walk ended without an accepted response")

endmodule

`default_nettype wire

// ===== tb/multichannel_led_pattern_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern generator testbench
// Runs directed and random command/tick beats against the block, tracks every
// channel's pattern in a behavioral model, and checks each response beat's
// LED levels and accepted flag, with random stalls on both channels and the
// channel count reprogrammed between phases.
// ----------------------------------------------------------------------------

module multichannel_led_pattern_generator_tb;

   localparam int NUM_CH    = 8;
   localparam int CYCLE_CAP = 300000;

   // Mode codes the block has no use for; must be dropped with accepted low.
   localparam logic [2:0] REQ_RSVD_6 = 3'd6;
   localparam logic [2:0] REQ_RSVD_7 = 3'd7;

   // ------------------------------------------------------------------------
   // Channel pattern model and response checker
   // ------------------------------------------------------------------------
   class led_scoreboard;
      lpg_pkg::lpg_chan_mode_type mode_tab [NUM_CH];
      logic [15:0]                period_tab [NUM_CH];
      logic [8:0]                 high_tab [NUM_CH];
      logic [7:0]                 low_tab [NUM_CH];
      logic [15:0]                phase_tab [NUM_CH];
      logic [15:0]                prescale_tab [NUM_CH];
      logic                       led_tab [NUM_CH];
      logic [3:0]                 chans_used;
      lpg_pkg::lpg_rsp_type       levels_expected [$];
      int unsigned                mismatches;
      int unsigned                beats_seen;

      function new();
         chans_used = lpg_pkg::CIN_RESET;
         mismatches = 0;
         beats_seen = 0;
         for (int c = 0; c < NUM_CH; c++) begin
            mode_tab[c]     = lpg_pkg::CM_OFF;
            period_tab[c]   = '0;
            high_tab[c]     = '0;
            low_tab[c]      = '0;
            phase_tab[c]    = '0;
            prescale_tab[c] = '0;
            led_tab[c]      = 1'b0;
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
      endfunction

      // Applies one accepted request beat and queues the response it yields.
      function bit note_request(lpg_pkg::lpg_req_type r);
         lpg_pkg::lpg_rsp_type       resp;
         lpg_pkg::lpg_chan_mode_type want;
         int unsigned                nxt;
         int unsigned                ph;
         int unsigned                hi;
         int unsigned                lo;
         int                         c;
         bit                         acc;
         acc = 1'b0;
         if (r.mode == lpg_pkg::REQ_TICK) begin
            acc = 1'b1;
            for (c = 0; c < NUM_CH; c++) begin
               if (mode_tab[c] inside {lpg_pkg::CM_BLINK, lpg_pkg::CM_PULSE,
                                       lpg_pkg::CM_TRAIN}) begin
                  nxt = 32'(prescale_tab[c]) + 1;
                  if (nxt < period_tab[c]) begin
                     prescale_tab[c] = 16'(nxt);
                  end else begin
                     // period expired: step the pattern
                     prescale_tab[c] = '0;
                     hi = 32'(high_tab[c]);
                     lo = 32'(low_tab[c]);
                     ph = 32'(phase_tab[c]) + 1;
                     case (mode_tab[c])
                        lpg_pkg::CM_BLINK: begin
                           phase_tab[c] = 16'(ph);
                           if (ph == lo) begin
                              led_tab[c] = 1'b1;
                           end else if (ph == hi + lo) begin
                              led_tab[c]   = 1'b0;
                              phase_tab[c] = '0;
                           end
                        end
                        lpg_pkg::CM_PULSE: begin
                           led_tab[c]  = 1'b0;
                           mode_tab[c] = lpg_pkg::CM_OFF;
                        end
                        lpg_pkg::CM_TRAIN: begin
                           phase_tab[c] = 16'(ph);
                           if (ph <= hi) begin
                              led_tab[c] = ph[0];
                           end else if (ph == hi + lo) begin
                              phase_tab[c] = '0;
                              led_tab[c]   = 1'b0;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end else if (r.mode <= lpg_pkg::REQ_TRAIN && r.channel < chans_used) begin
            c = int'(r.channel);
            case (r.mode)
               lpg_pkg::REQ_OFF, lpg_pkg::REQ_ON: begin
                  want = (r.mode == lpg_pkg::REQ_ON) ? lpg_pkg::CM_ON : lpg_pkg::CM_OFF;
                  if (mode_tab[c] != want) begin
                     mode_tab[c] = want;
                     led_tab[c]  = (want == lpg_pkg::CM_ON);
                  end
                  acc = 1'b1;
               end
               lpg_pkg::REQ_BLINK, lpg_pkg::REQ_TRAIN: begin
                  if (r.period != 0 && r.high_count != 0 && r.low_count != 0) begin
                     mode_tab[c]     = (r.mode == lpg_pkg::REQ_BLINK) ? lpg_pkg::CM_BLINK
                                                                      : lpg_pkg::CM_TRAIN;
                     period_tab[c]   = r.period;
                     // train keeps twice the pulse count, all 9 bits
                     high_tab[c]     = (r.mode == lpg_pkg::REQ_BLINK) ? {1'b0, r.high_count}
                                                                      : {r.high_count, 1'b0};
                     low_tab[c]      = r.low_count;
                     phase_tab[c]    = '0;
                     prescale_tab[c] = '0;
                     acc = 1'b1;
                  end
               end
               lpg_pkg::REQ_PULSE: begin
                  if (r.period != 0) begin
                     mode_tab[c]     = lpg_pkg::CM_PULSE;
                     period_tab[c]   = r.period;
                     phase_tab[c]    = '0;
                     prescale_tab[c] = '0;
                     led_tab[c]      = 1'b1;
                     acc = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         for (c = 0; c < NUM_CH; c++)
            resp.led_levels[c] = led_tab[c];
         resp.accepted = acc;
         levels_expected.push_back(resp);
         return acc;
      endfunction

      function void check_response(lpg_pkg::lpg_rsp_type got);
         lpg_pkg::lpg_rsp_type want;
         beats_seen++;
         if (levels_expected.size() == 0) begin
            flag($sformatf("response beat %0d with nothing expected (%02h/%0b)",
                           beats_seen, got.led_levels, got.accepted));
            return;
         end
         want = levels_expected.pop_front();
         if (got.led_levels !== want.led_levels)
            flag($sformatf("beat %0d led_levels exp %02h got %02h",
                           beats_seen, want.led_levels, got.led_levels));
         if (got.accepted !== want.accepted)
            flag($sformatf("beat %0d accepted exp %0b got %0b",
                           beats_seen, want.accepted, got.accepted));
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   lpg_pkg::lpg_req_type req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   lpg_pkg::lpg_rsp_type rsp_data;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [2:0]           csr_paddr   = '0;
   logic [31:0]          csr_pwdata  = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   multichannel_led_pattern_generator #(
      .NUM_CHANNELS (NUM_CH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   led_scoreboard sb = new();

   // Upper bound of the per-beat idle draw on each side; 0 means back-to-back.
   int unsigned req_gap_max   = 0;
   int unsigned rsp_stall_max = 0;
   int unsigned cycle_count   = 0;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a dropped beat ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response monitor; sampled at the rising edge, before any DUT update lands.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   // Response sink: random stall before each beat, then hold ready until taken.
   initial begin : rsp_sink
      int unsigned stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Drivers; all entered and left at a falling edge
   // ------------------------------------------------------------------------

   // Sends one request beat after a random gap. Valid stays up across
   // back-to-back beats; only the payload moves.
   task automatic send_beat(input lpg_pkg::lpg_req_type item, output bit acc);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      acc = sb.note_request(item);
      @(negedge clock);
   endtask

   // Sender holds off until every response is back and the block is quiet;
   // a tick's walk is the longest tail.
   task automatic drain;
      req_valid = 1'b0;
      while (sb.levels_expected.size() != 0) @(posedge clock);
      repeat (NUM_CH + 4) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the channel count, then read it back (setup/access each way).
   task automatic set_channels(input logic [3:0] count);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = lpg_pkg::CSR_ADDR_CIN;
      csr_pwdata  = {28'd0, count};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.chans_used = count;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {28'd0, count})
         sb.flag($sformatf("channels_in_use readback exp %0d got %08h",
                           count, csr_prdata));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic lpg_pkg::lpg_req_type make_req(logic [2:0] mode, logic [2:0] ch,
                                                     logic [15:0] per, logic [7:0] hc,
                                                     logic [7:0] lc);
      lpg_pkg::lpg_req_type r;
      r.mode       = mode;
      r.channel    = ch;
      r.period     = per;
      r.high_count = hc;
      r.low_count  = lc;
      return r;
   endfunction

   // Mostly ticks and short, small-count patterns so they actually cycle;
   // a slice of full-range fields and zeros keeps every bit and reject path hit.
   function automatic lpg_pkg::lpg_req_type random_req();
      lpg_pkg::lpg_req_type r;
      int unsigned          pick;
      pick      = $urandom_range(0, 99);
      r.channel = 3'($urandom_range(0, NUM_CH - 1));
      if (pick < 45)
         r.mode = lpg_pkg::REQ_TICK;
      else if (pick < 50)
         r.mode = ($urandom_range(0, 1) != 0) ? REQ_RSVD_6 : REQ_RSVD_7;
      else
         r.mode = 3'($urandom_range(32'(lpg_pkg::REQ_OFF), 32'(lpg_pkg::REQ_TRAIN)));
      pick = $urandom_range(0, 99);
      if (pick < 3)
         r.period = '0;
      else if (pick < 10)
         r.period = 16'($urandom);
      else
         r.period = 16'($urandom_range(1, 4));
      pick = $urandom_range(0, 99);
      r.high_count = (pick < 5) ? 8'd0 : (pick < 15) ? 8'($urandom) : 8'($urandom_range(1, 6));
      pick = $urandom_range(0, 99);
      r.low_count  = (pick < 5) ? 8'd0 : (pick < 15) ? 8'($urandom) : 8'($urandom_range(1, 6));
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      lpg_pkg::lpg_req_type directed [$];
      logic [3:0]           phase_counts [5];
      bit                   acc;
      int unsigned          sent;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset setting of eight channels, no idling.
      directed.push_back(make_req(lpg_pkg::REQ_TICK,  3'd5, 16'hFFFF, 8'hFF, 8'hFF));
      directed.push_back(make_req(lpg_pkg::REQ_OFF,   3'd0, 16'd0, 8'd0, 8'd0)); // already off
      directed.push_back(make_req(lpg_pkg::REQ_ON,    3'd7, 16'd0, 8'd0, 8'd0));
      directed.push_back(make_req(lpg_pkg::REQ_ON,    3'd7, 16'd0, 8'd0, 8'd0)); // already on
      directed.push_back(make_req(lpg_pkg::REQ_OFF,   3'd7, 16'd0, 8'd0, 8'd0));
      directed.push_back(make_req(REQ_RSVD_6,         3'd0, 16'd1, 8'd1, 8'd1));
      directed.push_back(make_req(REQ_RSVD_7,         3'd1, 16'd1, 8'd1, 8'd1));
      directed.push_back(make_req(lpg_pkg::REQ_BLINK, 3'd0, 16'd0, 8'd1, 8'd1)); // zero period
      directed.push_back(make_req(lpg_pkg::REQ_BLINK, 3'd0, 16'd1, 8'd0, 8'd1)); // zero on count
      directed.push_back(make_req(lpg_pkg::REQ_TRAIN, 3'd1, 16'd1, 8'd1, 8'd0)); // zero gap
      directed.push_back(make_req(lpg_pkg::REQ_PULSE, 3'd2, 16'd0, 8'd0, 8'd0)); // zero period
      directed.push_back(make_req(lpg_pkg::REQ_BLINK, 3'd0, 16'd1, 8'd2, 8'd1));
      directed.push_back(make_req(lpg_pkg::REQ_TRAIN, 3'd1, 16'd2, 8'd3, 8'd2));
      directed.push_back(make_req(lpg_pkg::REQ_PULSE, 3'd2, 16'd3, 8'd0, 8'd0));
      directed.push_back(make_req(lpg_pkg::REQ_TRAIN, 3'd3, 16'hFFFF, 8'hFF, 8'hFF));
      directed.push_back(make_req(lpg_pkg::REQ_BLINK, 3'd4, 16'd1, 8'hFF, 8'hFF));
      // doubled count needs bit 8
      directed.push_back(make_req(lpg_pkg::REQ_TRAIN, 3'd5, 16'd1, 8'd128, 8'd1));
      repeat (6) directed.push_back(make_req(lpg_pkg::REQ_TICK, 3'd0, 16'd0, 8'd0, 8'd0));
      // stops the blink
      directed.push_back(make_req(lpg_pkg::REQ_ON,    3'd0, 16'd0, 8'd0, 8'd0));
      directed.push_back(make_req(lpg_pkg::REQ_TICK,  3'd2, 16'h5555, 8'hAA, 8'h55));
      foreach (directed[i]) send_beat(directed[i], acc);

      // Random phases at several channel counts, extremes included. Each
      // starts from a fully drained block, so the sender waits on all
      // responses before every register write.
      phase_counts = '{4'd1, 4'd5, 4'd8, 4'd3, 4'd8};
      foreach (phase_counts[p]) begin
         drain();
         set_channels(phase_counts[p]);
         sent = 0;
         while (sent < 85) begin
            // every 40 beats, pick at random between busy and back-to-back stretches
            if (sent % 40 == 0) begin
               req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 16;
               rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            end
            send_beat(random_req(), acc);
            sent++;
         end
      end

      // Wrap up: everything back, then a tick's worth of quiet for strays.
      req_valid = 1'b0;
      while (sb.levels_expected.size() != 0) @(posedge clock);
      repeat (NUM_CH + 4) @(posedge clock);
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpg_pkg.sv
rtl/lpg_chan_mem.sv
rtl/lpg_update.sv
rtl/multichannel_led_pattern_generator.sv
tb/multichannel_led_pattern_generator_tb.sv
